// ----- hw/rtl/twcs_pkg.sv -----
// Package: types, codes and constants of the textured wall column sampler.
package twcs_pkg;

	localparam int TEX_SIZE = 64;
	localparam int TEX_BITS = $clog2(TEX_SIZE);
	localparam int MAX_DIM  = 2048;
	localparam int FACE_AW  = 12;
	localparam int STORE_AW = FACE_AW + 2;
	localparam int DIV_W    = TEX_BITS + 17;

	localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;
	localparam logic [23:0] SHADE_MASK        = 24'd8355711;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_ROW   = 2'd2;

	localparam logic [1:0] FACE_NORTH = 2'd0;
	localparam logic [1:0] FACE_SOUTH = 2'd1;
	localparam logic [1:0] FACE_EAST  = 2'd2;
	localparam logic [1:0] FACE_WEST  = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  texel_face;
		logic [11:0] texel_addr;
		logic [23:0] texel_color;
		logic        hit_side;
		logic        dir_x_negative;
		logic        dir_y_positive;
		logic [15:0] wall_frac;
		logic [15:0] slice_height;
		logic [10:0] first_row;
		logic [11:0] row_bound;
		logic [10:0] column;
	} cmd_t;

	typedef struct packed {
		logic [10:0] row;
		logic [10:0] pixel_column;
		logic [23:0] color;
		logic        write;
		logic        last;
	} pix_t;

endpackage

// ----- hw/rtl/textured_wall_column_sampler.sv -----
// Top level: texture store, column set-up sequencer with restoring divider, row sampler.
// A texel load and a row request on an empty column leave the sequencer idle; a row
// request that yields a pixel reads the store, then shades into the output register,
// waiting only while the output register is still held by the sink. A column start runs
// the restoring divider that forms the texture step one quotient bit per cycle, then the
// multiply that places the start position. The store is written on the transfer edge and
// is not cleared.
module textured_wall_column_sampler (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [11:0]       cfg_data,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  twcs_pkg::cmd_t    cmd,
	output logic              pix_valid,
	input  logic              pix_ready,
	output twcs_pkg::pix_t    pix
);

	localparam int TB    = twcs_pkg::TEX_BITS;
	localparam int DW    = twcs_pkg::DIV_W;
	localparam int CNT_W = $clog2(DW);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_EMIT} state_t;

	state_t                        state_q;
	logic [11:0]                   screen_height_q;
	logic [1:0]                    face_q;
	logic [TB-1:0]                 tex_column_q;
	logic [31:0]                   step_q;
	logic [31:0]                   pos_q;
	logic [10:0]                   cur_row_q;
	logic [11:0]                   end_row_q;
	logic [10:0]                   cur_column_q;
	logic signed [17:0]            offset_q;
	logic [15:0]                   lh_q;
	logic [15:0]                   rem_q;
	logic [DW-1:0]                 quo_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [10:0]                   pend_row_q;
	logic                          pend_last_q;
	logic                          pend_shade_q;
	logic                          pix_valid_q;
	twcs_pkg::pix_t                pix_q;

	logic [23:0] store [2**twcs_pkg::STORE_AW];
	logic [23:0] texel_q;

	logic                          take;
	logic [15:0]                   lh_fix;
	logic [1:0]                    face_d;
	logic [TB-1:0]                 tx_d;
	logic [11:0]                   de_clamp;
	logic [16:0]                   shifted;
	logic [17:0]                   diff;
	logic                          ge;
	logic signed [DW+18:0]         prod;
	logic                          pending;
	logic                          is_last;
	logic [2*TB+twcs_pkg::FACE_AW-1:0] fetch_wide;
	logic [twcs_pkg::STORE_AW-1:0] raddr;
	logic [twcs_pkg::STORE_AW-1:0] waddr;
	logic [23:0]                   shaded;

	assign cfg_ready = 1'b1;
	assign cmd_ready = (state_q == S_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	assign lh_fix = (cmd.slice_height == 16'd0) ? 16'd1 : cmd.slice_height;
	assign face_d = cmd.hit_side ?
		(cmd.dir_y_positive ? twcs_pkg::FACE_SOUTH : twcs_pkg::FACE_NORTH) :
		(cmd.dir_x_negative ? twcs_pkg::FACE_WEST : twcs_pkg::FACE_EAST);
	assign tx_d = (face_d == twcs_pkg::FACE_WEST || face_d == twcs_pkg::FACE_SOUTH) ?
		~cmd.wall_frac[15 -: TB] : cmd.wall_frac[15 -: TB];
	assign de_clamp = (cmd.row_bound > 12'(twcs_pkg::MAX_DIM)) ?
		12'(twcs_pkg::MAX_DIM) : cmd.row_bound;

	// restoring divide of TEX_SIZE<<16: dividend is a single one followed by zeros
	assign shifted = {rem_q, (cnt_q == '0)};
	assign diff    = {1'b0, shifted} - {2'b00, lh_q};
	assign ge      = !diff[17];
	assign prod    = offset_q * $signed({1'b0, quo_q});

	assign pending    = ({1'b0, cur_row_q} < end_row_q);
	assign is_last    = (({1'b0, cur_row_q} + 12'd1) >= end_row_q);
	assign fetch_wide = {{twcs_pkg::FACE_AW{1'b0}}, pos_q[16 +: TB], tex_column_q};
	assign raddr      = {face_q, fetch_wide[twcs_pkg::FACE_AW-1:0]};
	assign waddr      = {cmd.texel_face, cmd.texel_addr};
	assign shaded     = pend_shade_q ? ((texel_q >> 1) & twcs_pkg::SHADE_MASK) : texel_q;

	always_ff @(posedge clk) begin
		if (take && cmd.action == twcs_pkg::ACT_LOAD) begin
			store[waddr] <= cmd.texel_color;
		end
		if (take && cmd.action == twcs_pkg::ACT_ROW && pending) begin
			texel_q <= store[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			screen_height_q <= twcs_pkg::SCREEN_HEIGHT_RST;
			face_q          <= twcs_pkg::FACE_NORTH;
			tex_column_q    <= '0;
			step_q          <= '0;
			pos_q           <= '0;
			cur_row_q       <= '0;
			end_row_q       <= '0;
			cur_column_q    <= '0;
			offset_q        <= '0;
			lh_q            <= '0;
			rem_q           <= '0;
			quo_q           <= '0;
			cnt_q           <= '0;
			pend_row_q      <= '0;
			pend_last_q     <= 1'b0;
			pend_shade_q    <= 1'b0;
			pix_valid_q     <= 1'b0;
			pix_q           <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				screen_height_q <= cfg_data;
			end
			if (pix_valid_q && pix_ready && state_q != S_EMIT) begin
				pix_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take && cmd.action == twcs_pkg::ACT_START) begin
						face_q       <= face_d;
						tex_column_q <= tx_d;
						offset_q     <= 18'(cmd.first_row) - 18'(screen_height_q[11:1])
							+ 18'(lh_fix[15:1]);
						lh_q         <= lh_fix;
						rem_q        <= '0;
						quo_q        <= '0;
						cnt_q        <= '0;
						cur_column_q <= cmd.column;
						if ({1'b0, cmd.first_row} < de_clamp) begin
							cur_row_q <= cmd.first_row;
							end_row_q <= de_clamp;
						end else begin
							cur_row_q <= '0;
							end_row_q <= '0;
						end
						state_q <= S_DIV;
					end else if (take && cmd.action == twcs_pkg::ACT_ROW && pending) begin
						pos_q        <= pos_q + step_q;
						pend_row_q   <= cur_row_q;
						pend_last_q  <= is_last;
						pend_shade_q <= (face_q == twcs_pkg::FACE_NORTH) ||
							(face_q == twcs_pkg::FACE_EAST);
						if (is_last) begin
							cur_row_q <= '0;
							end_row_q <= '0;
						end else begin
							cur_row_q <= cur_row_q + 11'd1;
						end
						state_q <= S_EMIT;
					end
				end
				S_DIV: begin
					rem_q <= ge ? diff[15:0] : shifted[15:0];
					quo_q <= {quo_q[DW-2:0], ge};
					if (cnt_q == CNT_W'(DW - 1)) begin
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_MUL: begin
					step_q  <= 32'(quo_q);
					pos_q   <= prod[31:0];
					state_q <= S_IDLE;
				end
				S_EMIT: begin
					if (!pix_valid_q || pix_ready) begin
						pix_q.row          <= pend_row_q;
						pix_q.pixel_column <= cur_column_q;
						pix_q.color        <= shaded;
						pix_q.write        <= (shaded != 24'd0);
						pix_q.last         <= pend_last_q;
						pix_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/twcs_checker.sv -----
// Checker: port-level properties of the textured wall column sampler, bound to the top level.
module twcs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input twcs_pkg::cmd_t cmd,
	input logic           pix_valid,
	input logic           pix_ready,
	input twcs_pkg::pix_t pix
);

	// a stalled pixel transfer holds
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("pixel changed while stalled");

	// column set-up keeps the command side busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.action == twcs_pkg::ACT_START |=> !cmd_ready)
		else $error("command taken during column set-up");

	// a new pixel only follows an accepted row request
	a_pix_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_valid) |-> $past(cmd_valid && cmd_ready
			&& cmd.action == twcs_pkg::ACT_ROW, 2))
		else $error("pixel without row request");

	// transparent pixels carry no write
	a_pix_write: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |-> pix.write == (pix.color != 24'd0))
		else $error("write flag disagrees with colour");

endmodule

bind textured_wall_column_sampler twcs_checker u_twcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.pix       (pix)
);

// ----- tb/sv/twcs_column_checker.sv -----
`timescale 1ns / 1ps
// Checker: watches the register, command and pixel channels, predicts pixels and compares them.
module twcs_column_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic [11:0]    cfg_data,
	input  logic           cmd_valid,
	input  logic           cmd_ready,
	input  twcs_pkg::cmd_t cmd,
	input  logic           pix_valid,
	input  logic           pix_ready,
	input  twcs_pkg::pix_t pix,
	output int             mismatches,
	output int             outstanding
);

	logic [23:0]                   texels [0:(1 << twcs_pkg::STORE_AW) - 1];
	logic [11:0]                   screen_rows = twcs_pkg::SCREEN_HEIGHT_RST;
	logic [1:0]                    wall_face   = twcs_pkg::FACE_NORTH;
	logic [twcs_pkg::TEX_BITS-1:0] tex_x       = '0;
	logic [31:0]                   v_step      = '0;
	logic [31:0]                   v_pos       = '0;
	logic [10:0]                   next_row    = '0;
	logic [11:0]                   stop_row    = '0;
	logic [10:0]                   pix_col     = '0;
	twcs_pkg::pix_t                pending_pixels [$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	// Applies one accepted command; a row request with rows left queues one pixel.
	task automatic sample_wall(input twcs_pkg::cmd_t c);
		logic [31:0]    tx;
		logic [31:0]    lh;
		logic [31:0]    offset;
		logic [31:0]    ty;
		logic [31:0]    addr;
		logic [11:0]    de;
		twcs_pkg::pix_t want;
		case (c.action)
		twcs_pkg::ACT_LOAD: texels[{c.texel_face, c.texel_addr}] = c.texel_color;
		twcs_pkg::ACT_START: begin
			if (c.hit_side)
				wall_face = c.dir_y_positive ? twcs_pkg::FACE_SOUTH : twcs_pkg::FACE_NORTH;
			else
				wall_face = c.dir_x_negative ? twcs_pkg::FACE_WEST : twcs_pkg::FACE_EAST;
			tx = (32'(c.wall_frac) * twcs_pkg::TEX_SIZE) >> 16;
			if (wall_face == twcs_pkg::FACE_WEST || wall_face == twcs_pkg::FACE_SOUTH)
				tx = twcs_pkg::TEX_SIZE - 1 - tx;
			tex_x = tx[twcs_pkg::TEX_BITS-1:0];
			lh = (c.slice_height == '0) ? 32'd1 : 32'(c.slice_height);
			v_step = 32'((64'(twcs_pkg::TEX_SIZE) << 16) / 64'(lh));
			offset = 32'(c.first_row) - 32'(screen_rows >> 1) + (lh >> 1);
			v_pos = offset * v_step;
			de = (c.row_bound > twcs_pkg::MAX_DIM) ? 12'(twcs_pkg::MAX_DIM) : c.row_bound;
			pix_col = c.column;
			if (32'(c.first_row) < 32'(de)) begin
				next_row = c.first_row;
				stop_row = de;
			end else begin
				next_row = '0;
				stop_row = '0;
			end
		end
		twcs_pkg::ACT_ROW: begin
			if (32'(next_row) < 32'(stop_row)) begin
				ty = (v_pos >> 16) & (twcs_pkg::TEX_SIZE - 1);
				v_pos = v_pos + v_step;
				addr = (twcs_pkg::TEX_SIZE * ty + 32'(tex_x)) & ((1 << twcs_pkg::FACE_AW) - 1);
				want.color = texels[{wall_face, addr[twcs_pkg::FACE_AW-1:0]}];
				// north and east faces are shaded darker
				if (wall_face == twcs_pkg::FACE_NORTH || wall_face == twcs_pkg::FACE_EAST)
					want.color = (want.color >> 1) & twcs_pkg::SHADE_MASK;
				want.row = next_row;
				want.pixel_column = pix_col;
				want.write = (want.color != '0);
				want.last = (32'(next_row) + 1 >= 32'(stop_row));
				if (want.last) begin
					next_row = '0;
					stop_row = '0;
				end else begin
					next_row = next_row + 1'b1;
				end
				pending_pixels.push_back(want);
			end
		end
		default: ;
		endcase
	endtask

	always @(posedge clk) begin
		twcs_pkg::pix_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				screen_rows = cfg_data;
			// compare before predicting: a command cannot produce a pixel on its own transfer edge
			if (pix_valid && pix_ready) begin
				if (pending_pixels.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: pixel with none due: row %0d col %0d colour %06h w %0b l %0b",
							$realtime, pix.row, pix.pixel_column, pix.color, pix.write, pix.last);
					mismatches++;
				end else begin
					want = pending_pixels.pop_front();
					if (pix.row !== want.row || pix.pixel_column !== want.pixel_column ||
						pix.color !== want.color || pix.write !== want.write ||
						pix.last !== want.last) begin
						if (mismatches < 10) begin
							$display("%0t: pixel mismatch", $realtime);
							$display("  expected row %0d col %0d colour %06h w %0b l %0b",
								want.row, want.pixel_column, want.color, want.write, want.last);
							$display("  actual   row %0d col %0d colour %06h w %0b l %0b",
								pix.row, pix.pixel_column, pix.color, pix.write, pix.last);
						end
						mismatches++;
					end
				end
			end
			if (cmd_valid && cmd_ready)
				sample_wall(cmd);
			outstanding = pending_pixels.size();
		end
	end

endmodule

// ----- tb/sv/textured_wall_column_sampler_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: clock, reset, texel/column/row stimulus, sink back-pressure and verdict.
module textured_wall_column_sampler_tb;

	localparam int         CLK_PERIOD       = 4;
	localparam int         RESET_CYCLES     = 12;
	localparam int         SETTLE_CYCLES    = 40;
	localparam int         LONG_HOLD_CYCLES = 300;
	localparam longint     TIMEOUT_NS       = 4_000_000;
	localparam logic [1:0] ACT_UNUSED       = 2'd3;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [11:0]    cfg_data;
	logic           cmd_valid;
	logic           cmd_ready;
	twcs_pkg::cmd_t cmd;
	logic           pix_valid;
	logic           pix_ready;
	twcs_pkg::pix_t pix;
	int             mismatches;
	int             outstanding;

	bit                          texel_loaded [0:(1 << twcs_pkg::STORE_AW) - 1];
	bit [twcs_pkg::TEX_SIZE-1:0] full_cols [4];
	int                          rows_left;
	int                          item_count;
	bit                          steady;
	bit                          long_hold;

	always #(CLK_PERIOD / 2) clk = ~clk;

	textured_wall_column_sampler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	twcs_column_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pix         (pix),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic twcs_pkg::cmd_t noise_cmd();
		logic [127:0] r;
		r = {$urandom, $urandom, $urandom, $urandom};
		return r[$bits(twcs_pkg::cmd_t)-1:0];
	endfunction

	// zero gives a transparent pixel; one shades to zero on north and east faces
	function automatic logic [23:0] pick_colour();
		case ($urandom_range(0, 7))
		0: return 24'h000000;
		1: return 24'h000001;
		2: return 24'hFFFFFF;
		default: return 24'($urandom);
		endcase
	endfunction

	function automatic int pick_tex_column(input logic [1:0] face);
		int k;
		if (full_cols[face] == '0 || $urandom_range(0, 59) == 0)
			return $urandom_range(0, twcs_pkg::TEX_SIZE - 1);
		k = $urandom_range(0, twcs_pkg::TEX_SIZE - 1);
		while (!full_cols[face][k])
			k = (k + 1) % twcs_pkg::TEX_SIZE;
		return k;
	endfunction

	task automatic send_cmd(input twcs_pkg::cmd_t c);
		if (!steady && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
	endtask

	task automatic load_texel(input logic [1:0] face, input logic [11:0] addr,
		input logic [23:0] colour);
		twcs_pkg::cmd_t c;
		c = noise_cmd();
		c.action = twcs_pkg::ACT_LOAD;
		c.texel_face = face;
		c.texel_addr = addr;
		c.texel_color = colour;
		send_cmd(c);
		texel_loaded[{face, addr}] = 1'b1;
		item_count++;
	endtask

	// Fills the whole texture column first, so every fetch of the column hits a written texel.
	task automatic open_column(input logic [1:0] face, input logic [15:0] frac,
		input logic [15:0] lh, input logic [10:0] ds, input logic [11:0] de,
		input logic [10:0] col);
		twcs_pkg::cmd_t                c;
		logic [twcs_pkg::TEX_BITS-1:0] tx;
		logic [11:0]                   de_eff;
		logic [11:0]                   addr;
		int                            tc;
		int                            rows_due;
		tx = frac[15 -: twcs_pkg::TEX_BITS];
		tc = (face == twcs_pkg::FACE_WEST || face == twcs_pkg::FACE_SOUTH) ?
			twcs_pkg::TEX_SIZE - 1 - tx : tx;
		de_eff = (de > twcs_pkg::MAX_DIM) ? 12'(twcs_pkg::MAX_DIM) : de;
		rows_due = (ds < de_eff) ? de_eff - ds : 0;
		if (rows_due > 0) begin
			for (int r = 0; r < twcs_pkg::TEX_SIZE; r++) begin
				addr = 12'(r * twcs_pkg::TEX_SIZE + tc);
				if (!texel_loaded[{face, addr}])
					load_texel(face, addr, pick_colour());
			end
			full_cols[face][tc] = 1'b1;
		end
		c = noise_cmd();
		c.action = twcs_pkg::ACT_START;
		case (face)
		twcs_pkg::FACE_NORTH: begin
			c.hit_side = 1'b1;
			c.dir_y_positive = 1'b0;
		end
		twcs_pkg::FACE_SOUTH: begin
			c.hit_side = 1'b1;
			c.dir_y_positive = 1'b1;
		end
		twcs_pkg::FACE_EAST: begin
			c.hit_side = 1'b0;
			c.dir_x_negative = 1'b0;
		end
		default: begin
			c.hit_side = 1'b0;
			c.dir_x_negative = 1'b1;
		end
		endcase
		c.wall_frac = frac;
		c.slice_height = lh;
		c.first_row = ds;
		c.row_bound = de;
		c.column = col;
		send_cmd(c);
		rows_left = rows_due;
		item_count++;
	endtask

	task automatic request_row();
		twcs_pkg::cmd_t c;
		c = noise_cmd();
		c.action = twcs_pkg::ACT_ROW;
		send_cmd(c);
		if (rows_left > 0) begin
			rows_left--;
			item_count++;
		end
	endtask

	task automatic send_unused();
		twcs_pkg::cmd_t c;
		c = noise_cmd();
		c.action = ACT_UNUSED;
		send_cmd(c);
	endtask

	task automatic write_height(input logic [11:0] value);
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		// a column start still in its divide may yield no pixel yet
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int budget);
		int          target;
		int          pick;
		int          tc;
		int          tx;
		int          n;
		logic [1:0]  face;
		logic [15:0] frac;
		logic [15:0] lh;
		logic [10:0] ds;
		logic [11:0] de;
		target = item_count + budget;
		while (item_count < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				face = 2'($urandom_range(0, 3));
				tc = pick_tex_column(face);
				tx = (face == twcs_pkg::FACE_WEST || face == twcs_pkg::FACE_SOUTH) ?
					twcs_pkg::TEX_SIZE - 1 - tc : tc;
				frac = 16'((tx << (16 - twcs_pkg::TEX_BITS)) |
					$urandom_range(0, (1 << (16 - twcs_pkg::TEX_BITS)) - 1));
				case ($urandom_range(0, 3))
				0: lh = 16'($urandom_range(0, 8));
				1: lh = 16'($urandom_range(9, 255));
				2: lh = 16'($urandom_range(256, 4095));
				default: lh = 16'($urandom_range(0, 65535));
				endcase
				ds = 11'($urandom_range(0, twcs_pkg::MAX_DIM - 1));
				if ($urandom_range(0, 19) == 0)
					de = 12'($urandom_range(0, ds));
				else if ($urandom_range(0, 9) == 0)
					de = 12'(ds + $urandom_range(17, 120));
				else
					de = 12'(ds + $urandom_range(1, 16));
				open_column(face, frac, lh, ds, de, 11'($urandom));
				n = rows_left;
				case ($urandom_range(0, 9))
				0: n = $urandom_range(0, n);          // restart mid-column
				1: n = n + $urandom_range(1, 2);      // rows past the end
				default: ;
				endcase
				repeat (n) request_row();
			end else if (pick < 85) begin
				load_texel(2'($urandom), 12'($urandom), pick_colour());
			end else if (pick < 92) begin
				send_unused();
			end else begin
				request_row();
			end
		end
	endtask

	initial begin : sink
		pix_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				pix_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				pix_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				pix_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		rows_left = 0;
		item_count = 0;
		steady = 1'b0;
		long_hold = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		request_row();        // nothing pending after reset
		send_unused();
		open_column(twcs_pkg::FACE_NORTH, 16'h0000, 16'd1, 11'd0, 12'd3, 11'd0);
		repeat (4) request_row();
		// end far beyond the screen is clamped; single last row
		open_column(twcs_pkg::FACE_SOUTH, 16'hFFFF, 16'hFFFF, 11'd2047, 12'd4095, 11'd2047);
		request_row();
		// zero line height, then restart drops the remaining rows
		open_column(twcs_pkg::FACE_EAST, 16'h5555, 16'd0, 11'd2040, 12'd2048, 11'd1024);
		repeat (2) request_row();
		open_column(twcs_pkg::FACE_WEST, 16'h0000, 16'd64, 11'd100, 12'd100, 11'd555);
		request_row();
		open_column(twcs_pkg::FACE_WEST, 16'h8000, 16'd500, 11'd200, 12'd5, 11'd1);
		open_column(twcs_pkg::FACE_WEST, 16'h03FF, 16'd500, 11'd300, 12'd305, 11'd1365);
		repeat (5) request_row();
		open_column(twcs_pkg::FACE_EAST, 16'h55AA, 16'd3, 11'd1000, 12'd1006, 11'd682);
		repeat (6) request_row();

		random_phase(120);

		write_height(12'd2048);
		// sink holds off while rows keep coming, so the block backs up
		long_hold = 1'b1;
		open_column(twcs_pkg::FACE_NORTH, 16'h0000, 16'd40, 11'd0, 12'd90, 11'd7);
		repeat (90) request_row();
		random_phase(110);

		write_height(12'd1);
		random_phase(100);

		write_height(12'hFFF);
		random_phase(90);

		write_height(12'($urandom_range(1, twcs_pkg::MAX_DIM)));
		random_phase(90);

		write_height(twcs_pkg::SCREEN_HEIGHT_RST);
		steady = 1'b1;
		random_phase(100);

		cmd_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/twcs_pkg.sv
hw/rtl/textured_wall_column_sampler.sv
hw/rtl/twcs_checker.sv
tb/sv/twcs_column_checker.sv
tb/sv/textured_wall_column_sampler_tb.sv
